[rtl/core/frsc_pkg.sv]
// frsc_pkg: shared types and codes for the frame slot lru cache
// no dependencies; imported by frsc_cell and frame_slot_lru_cache_core
package frsc_pkg;

    // widest slot index that the SLOTS range can need
    localparam int IDX_W = 8;
    localparam int AGE_W = 48;
    localparam int DIM_W = 14;

    localparam logic [1:0] MODE_LOOKUP = 2'd0;
    localparam logic [1:0] MODE_STORE  = 2'd1;
    localparam logic [1:0] MODE_PROBE  = 2'd2;
    localparam logic [1:0] MODE_CLEAR  = 2'd3;

    localparam logic [2:0] ST_HIT    = 3'd0;
    localparam logic [2:0] ST_MISS   = 3'd1;
    localparam logic [2:0] ST_FREE   = 3'd2;
    localparam logic [2:0] ST_EVICT  = 3'd3;
    localparam logic [2:0] ST_REJECT = 3'd4;
    localparam logic [2:0] ST_CLEAR  = 3'd5;

    localparam logic CFG_EXP_WIDTH  = 1'b0;
    localparam logic CFG_EXP_HEIGHT = 1'b1;

    typedef struct packed {
        logic [1:0]       mode;
        logic [31:0]      frame_index;
        logic [DIM_W-1:0] item_width;
        logic [DIM_W-1:0] item_height;
        logic             planes_present;
    } t_in;

    typedef struct packed {
        logic [2:0]  status;
        logic [3:0]  slot_index;
        logic [31:0] evicted_frame;
        logic [4:0]  entry_count;
    } t_out;

    // search packet passed from cell to cell
    typedef struct packed {
        logic [31:0]      frame;
        logic             hit;
        logic [IDX_W-1:0] hit_idx;
        logic             free;
        logic [IDX_W-1:0] free_idx;
        logic             have_min;
        logic [IDX_W-1:0] min_idx;
        logic [AGE_W-1:0] min_age;
        logic [31:0]      min_frame;
    } t_scan;

    // update broadcast to all cells when an item finishes
    typedef struct packed {
        logic             clear;
        logic             touch;
        logic             alloc;
        logic [IDX_W-1:0] idx;
        logic [31:0]      frame;
        logic [AGE_W-1:0] age;
    } t_cmd;

endpackage

[rtl/core/frsc_cell.sv]
// frsc_cell: one cache slot (tag, valid, age) plus one stage of the search chain
// depends on frsc_pkg
module frsc_cell
    import frsc_pkg::*;
#(
    parameter logic [IDX_W-1:0] IDX = '0
) (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_pv,
    input  t_scan i_pkt,
    output logic  o_pv,
    output t_scan o_pkt,
    input  t_cmd  i_cmd
);

    logic             r_valid;
    logic [31:0]      r_frame;
    logic [AGE_W-1:0] r_age;
    logic             r_pv;
    t_scan            r_pkt;
    t_scan            n_pkt;
    logic             w_sel;

    assign w_sel = (i_cmd.idx == IDX);

    always_comb begin
        n_pkt = i_pkt;
        if (r_valid && (r_frame == i_pkt.frame) && !i_pkt.hit) begin
            n_pkt.hit     = 1'b1;
            n_pkt.hit_idx = IDX;
        end
        if (!r_valid && !i_pkt.free) begin
            n_pkt.free     = 1'b1;
            n_pkt.free_idx = IDX;
        end
        // strict compare keeps the lower slot on equal ages
        if (r_valid && (!i_pkt.have_min || (r_age < i_pkt.min_age))) begin
            n_pkt.have_min  = 1'b1;
            n_pkt.min_idx   = IDX;
            n_pkt.min_age   = r_age;
            n_pkt.min_frame = r_frame;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_pv    <= 1'b0;
        end else begin
            r_pv <= i_pv;
            if (i_cmd.clear) begin
                r_valid <= 1'b0;
            end else if (i_cmd.alloc && w_sel) begin
                r_valid <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_pv) begin
            r_pkt <= n_pkt;
        end
        if (i_cmd.touch && w_sel) begin
            r_age <= i_cmd.age;
        end
        if (i_cmd.alloc && w_sel) begin
            r_frame <= i_cmd.frame;
        end
    end

    assign o_pv  = r_pv;
    assign o_pkt = r_pkt;

endmodule

[rtl/core/frame_slot_lru_cache_core.sv]
// frame_slot_lru_cache_core: top level of the frame slot lru cache
// depends on frsc_pkg and frsc_cell
//
// Maps 32-bit frame numbers to SLOTS buffer slots with least-recently-used
// replacement driven by a 48-bit age counter.
// Input channel (i_in_valid / o_in_stall / i_in): one request per transfer,
// mode lookup, store, probe or clear. Output channel (o_out_valid /
// i_out_stall / o_out): one result per request, in request order.
// Config channel (i_cfg_valid / o_cfg_ready): sets the expected frame width
// and height; always ready, write only while no request is in flight.
// Lookup, probe and accepted stores send a search packet down the row of
// slot cells, registered once in each cell, then capture it in S_SCAN and
// answer from S_FINISH. Clear and rejected stores go straight to S_FINISH.
// One request is handled at a time: the input stalls until the last one
// has left S_FINISH, so no new request is taken before it is through.
// The result sits in an output register; while the receiver stalls it holds,
// and a finished request waits until that register is free.
// Reset empties every slot, zeroes the age counter and loads the
// configuration defaults 1920 x 1080.
module frame_slot_lru_cache_core
    import frsc_pkg::*;
#(
    parameter int SLOTS = 16
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_stall,
    input  t_in              i_in,
    output logic             o_out_valid,
    input  logic             i_out_stall,
    output t_out             o_out,
    input  logic             i_cfg_valid,
    output logic             o_cfg_ready,
    input  logic             i_cfg_index,
    input  logic [DIM_W-1:0] i_cfg_data
);

    localparam int CW = $clog2(SLOTS + 1);

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_FINISH
    } t_state;

    t_state           r_state;
    logic             r_out_valid;
    t_out             r_out;
    logic [1:0]       r_mode;
    logic             r_rej;
    t_scan            r_scan;
    logic [AGE_W-1:0] r_ctr;
    logic [CW-1:0]    r_count;
    logic [DIM_W-1:0] r_exp_w;
    logic [DIM_W-1:0] r_exp_h;

    logic             w_in_fire;
    logic             w_rej;
    logic             w_can_load;
    logic             w_fin_fire;
    logic             w_scan_start;
    t_scan            w_pkt0;
    t_cmd             w_cmd;
    t_out             n_out;
    logic [AGE_W-1:0] n_ctr;
    logic [CW-1:0]    n_count;

    logic             w_pv  [0:SLOTS];
    t_scan            w_pkt [0:SLOTS];

    // configuration
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_exp_w <= DIM_W'(1920);
            r_exp_h <= DIM_W'(1080);
        end else if (i_cfg_valid) begin
            if (i_cfg_index == CFG_EXP_WIDTH) begin
                r_exp_w <= i_cfg_data;
            end
            if (i_cfg_index == CFG_EXP_HEIGHT) begin
                r_exp_h <= i_cfg_data;
            end
        end
    end

    assign o_in_stall = (r_state != S_IDLE);
    assign w_in_fire  = i_in_valid && !o_in_stall;
    assign w_rej      = (i_in.mode == MODE_STORE)
                        && ((i_in.item_width != r_exp_w) || (i_in.item_height != r_exp_h)
                            || !i_in.planes_present);
    assign w_scan_start = w_in_fire && (i_in.mode != MODE_CLEAR) && !w_rej;

    always_comb begin
        w_pkt0       = '0;
        w_pkt0.frame = i_in.frame_index;
    end

    assign w_pv[0]  = w_scan_start;
    assign w_pkt[0] = w_pkt0;

    genvar g;
    generate
        for (g = 0; g < SLOTS; g++) begin : g_cell
            frsc_cell #(
                .IDX (IDX_W'(g))
            ) u_cell (
                .i_clk   (i_clk),
                .i_rst_n (i_rst_n),
                .i_pv    (w_pv[g]),
                .i_pkt   (w_pkt[g]),
                .o_pv    (w_pv[g+1]),
                .o_pkt   (w_pkt[g+1]),
                .i_cmd   (w_cmd)
            );
        end
    endgenerate

    assign w_can_load = !r_out_valid || !i_out_stall;
    assign w_fin_fire = (r_state == S_FINISH) && w_can_load;

    // decide the outcome in S_FINISH, for a search once its packet has left the last cell
    always_comb begin
        n_out       = '0;
        n_ctr       = r_ctr;
        n_count     = r_count;
        w_cmd       = '0;
        w_cmd.frame = r_scan.frame;
        w_cmd.age   = r_ctr + AGE_W'(1);
        if (r_mode == MODE_CLEAR) begin
            n_out.status = ST_CLEAR;
            n_ctr        = '0;
            n_count      = '0;
            w_cmd.clear  = 1'b1;
        end else if (r_rej) begin
            n_out.status = ST_REJECT;
        end else if (r_scan.hit) begin
            n_out.status     = ST_HIT;
            n_out.slot_index = 4'(r_scan.hit_idx);
            if (r_mode != MODE_PROBE) begin
                w_cmd.touch = 1'b1;
                w_cmd.idx   = r_scan.hit_idx;
                n_ctr       = r_ctr + AGE_W'(1);
            end
        end else if (r_mode != MODE_STORE) begin
            n_out.status = ST_MISS;
        end else begin
            w_cmd.touch = 1'b1;
            w_cmd.alloc = 1'b1;
            n_ctr       = r_ctr + AGE_W'(1);
            if (r_scan.free) begin
                n_out.status     = ST_FREE;
                n_out.slot_index = 4'(r_scan.free_idx);
                w_cmd.idx        = r_scan.free_idx;
                n_count          = r_count + CW'(1);
            end else begin
                n_out.status        = ST_EVICT;
                n_out.slot_index    = 4'(r_scan.min_idx);
                n_out.evicted_frame = r_scan.min_frame;
                w_cmd.idx           = r_scan.min_idx;
            end
        end
        n_out.entry_count = 5'(n_count);
        if (!w_fin_fire) begin
            w_cmd.clear = 1'b0;
            w_cmd.touch = 1'b0;
            w_cmd.alloc = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            r_ctr       <= '0;
            r_count     <= '0;
        end else begin
            if (w_fin_fire) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && !i_out_stall) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (w_in_fire) begin
                        r_mode <= i_in.mode;
                        r_rej  <= w_rej;
                        if ((i_in.mode == MODE_CLEAR) || w_rej) begin
                            r_state <= S_FINISH;
                        end else begin
                            r_state <= S_SCAN;
                        end
                    end
                end
                S_SCAN: begin
                    if (w_pv[SLOTS]) begin
                        r_scan  <= w_pkt[SLOTS];
                        r_state <= S_FINISH;
                    end
                end
                S_FINISH: begin
                    if (w_can_load) begin
                        r_out       <= n_out;
                        r_ctr       <= n_ctr;
                        r_count     <= n_count;
                        r_state     <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        32'(r_count) <= SLOTS)
        else $error("occupied count above slot count");

    a_chain_in_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_pv[SLOTS] |-> (r_state == S_SCAN))
        else $error("search packet left the chain outside a scan");

    a_evict_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_fin_fire && (n_out.status == ST_EVICT)) |-> (32'(r_count) == SLOTS))
        else $error("eviction while a slot is free");

    a_clear_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_fin_fire && (r_mode == MODE_CLEAR)) |=> (r_count == '0) && (r_ctr == '0))
        else $error("clear left entries or age behind");

endmodule

[verif/frsc_checker.sv]
`timescale 1ns / 1ps
// frsc_checker: watches the request, result and register channels of the frame slot cache,
// keeps its own copy of the slot tags and ages, and compares every result transfer
// depends on frsc_pkg only
module frsc_checker
    import frsc_pkg::*;
#(
    parameter int SLOTS = 16
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    input  logic             i_in_stall,
    input  t_in              i_in,
    input  logic             i_out_valid,
    input  logic             i_out_stall,
    input  t_out             i_out,
    input  logic             i_cfg_valid,
    input  logic             i_cfg_ready,
    input  logic             i_cfg_index,
    input  logic [DIM_W-1:0] i_cfg_data,
    output int               o_fail_count,
    output int               o_pending
);

    logic [DIM_W-1:0] size_w;
    logic [DIM_W-1:0] size_h;
    logic [31:0]      tag       [SLOTS];
    logic             tag_valid [SLOTS];
    logic [AGE_W-1:0] tag_age   [SLOTS];
    logic [AGE_W-1:0] age_now;
    int unsigned      used;
    t_out             results_due[$];

    function automatic void refresh_age(input int slot);
        age_now       = age_now + 1'b1;
        tag_age[slot] = age_now;
    endfunction

    function automatic t_out serve_request(input t_in req);
        t_out rsp;
        int   hit;
        int   pick;
        rsp  = '0;
        hit  = -1;
        pick = -1;
        if (req.mode == MODE_CLEAR) begin
            foreach (tag_valid[i]) tag_valid[i] = 1'b0;
            used       = 0;
            age_now    = '0;
            rsp.status = ST_CLEAR;
        end else if (req.mode == MODE_STORE && (req.item_width != size_w ||
                     req.item_height != size_h || !req.planes_present)) begin
            // size or plane check comes before any tag search
            rsp.status = ST_REJECT;
        end else begin
            for (int i = 0; i < SLOTS; i++)
                if (hit < 0 && tag_valid[i] && tag[i] == req.frame_index) hit = i;
            if (hit >= 0) begin
                if (req.mode != MODE_PROBE) refresh_age(hit);
                rsp.status     = ST_HIT;
                rsp.slot_index = hit[3:0];
            end else if (req.mode != MODE_STORE) begin
                rsp.status = ST_MISS;
            end else begin
                for (int i = 0; i < SLOTS; i++)
                    if (pick < 0 && !tag_valid[i]) pick = i;
                if (pick >= 0) begin
                    rsp.status = ST_FREE;
                    used++;
                end else begin
                    // oldest age wins, strict compare keeps the lower index on a tie
                    pick = 0;
                    for (int i = 1; i < SLOTS; i++)
                        if (tag_age[i] < tag_age[pick]) pick = i;
                    rsp.evicted_frame = tag[pick];
                    rsp.status        = ST_EVICT;
                end
                tag[pick]       = req.frame_index;
                tag_valid[pick] = 1'b1;
                refresh_age(pick);
                rsp.slot_index = pick[3:0];
            end
        end
        rsp.entry_count = used[4:0];
        return rsp;
    endfunction

    function automatic void report(input string field, input logic [31:0] want,
                                   input logic [31:0] got);
        $error("%s: expected %0d, got %0d", field, want, got);
        o_fail_count++;
    endfunction

    always @(posedge i_clk) begin
        t_out want;
        if (!i_rst_n) begin
            foreach (tag_valid[i]) tag_valid[i] = 1'b0;
            age_now      = '0;
            used         = 0;
            size_w       = 14'd1920;
            size_h       = 14'd1080;
            o_fail_count = 0;
            results_due.delete();
        end else begin
            if (i_cfg_valid && i_cfg_ready) begin
                if (i_cfg_index == CFG_EXP_WIDTH) size_w = i_cfg_data;
                else size_h = i_cfg_data;
            end
            if (i_out_valid && !i_out_stall) begin
                if (results_due.size() == 0) begin
                    $error("result transfer with no request outstanding");
                    o_fail_count++;
                end else begin
                    want = results_due.pop_front();
                    if (i_out.status !== want.status)
                        report("status", 32'(want.status), 32'(i_out.status));
                    if (i_out.slot_index !== want.slot_index)
                        report("slot_index", 32'(want.slot_index), 32'(i_out.slot_index));
                    if (i_out.evicted_frame !== want.evicted_frame)
                        report("evicted_frame", want.evicted_frame, i_out.evicted_frame);
                    if (i_out.entry_count !== want.entry_count)
                        report("entry_count", 32'(want.entry_count),
                               32'(i_out.entry_count));
                end
            end
            if (i_in_valid && !i_in_stall) results_due.push_back(serve_request(i_in));
        end
        o_pending = results_due.size();
    end

endmodule

[verif/tb.sv]
`timescale 1ns / 1ps
// tb: stimulus, register phases and verdict for frame_slot_lru_cache_core
// depends on frsc_pkg, frsc_checker and the core rtl
module tb;
    import frsc_pkg::*;

    localparam int SLOTS          = 16;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int CHUNK          = 275;
    localparam int CHUNKS         = 7;

    logic             clk       = 1'b0;
    logic             rst_n     = 1'b0;
    logic             in_valid  = 1'b0;
    logic             in_stall;
    t_in              in_req    = '0;
    logic             out_valid;
    logic             out_stall = 1'b0;
    t_out             out_rsp;
    logic             cfg_valid = 1'b0;
    logic             cfg_ready;
    logic             cfg_index = CFG_EXP_WIDTH;
    logic [DIM_W-1:0] cfg_data  = '0;
    logic             calm      = 1'b0;
    logic [DIM_W-1:0] want_w    = 14'd1920;
    logic [DIM_W-1:0] want_h    = 14'd1080;
    int               stall_left  = 0;
    int               idle_cycles = 0;
    int               fail_count;
    int               pending;

    always #6 clk = ~clk;

    frame_slot_lru_cache_core #(.SLOTS(SLOTS)) u_top (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in        (in_req),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out       (out_rsp),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (cfg_ready),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    frsc_checker #(.SLOTS(SLOTS)) u_check (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_in_valid   (in_valid),
        .i_in_stall   (in_stall),
        .i_in         (in_req),
        .i_out_valid  (out_valid),
        .i_out_stall  (out_stall),
        .i_out        (out_rsp),
        .i_cfg_valid  (cfg_valid),
        .i_cfg_ready  (cfg_ready),
        .i_cfg_index  (cfg_index),
        .i_cfg_data   (cfg_data),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    // mostly short gaps, now and then a long one
    function automatic int draw_gap();
        int roll;
        roll = $urandom_range(0, 99);
        if (calm) return 0;
        if (roll < 55) return 0;
        if (roll < 88) return $urandom_range(1, 3);
        if (roll < 97) return $urandom_range(4, 20);
        return $urandom_range(30, 120);
    endfunction

    always @(negedge clk) begin
        if (stall_left > 0) begin
            out_stall  <= 1'b1;
            stall_left <= stall_left - 1;
        end else begin
            out_stall <= 1'b0;
            if (!calm && $urandom_range(0, 2) == 0) stall_left <= draw_gap();
        end
    end

    always @(posedge clk) begin
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall) ||
            (cfg_valid && cfg_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("Regression FAIL");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    function automatic t_in mk(input logic [1:0] mode, input logic [31:0] frame,
                               input logic [DIM_W-1:0] w, input logic [DIM_W-1:0] h,
                               input logic planes);
        t_in req;
        req.mode           = mode;
        req.frame_index    = frame;
        req.item_width     = w;
        req.item_height    = h;
        req.planes_present = planes;
        return req;
    endfunction

    // frames mostly from a pool a little larger than the slot count, so hits and
    // evictions are common; stores mostly well formed
    function automatic t_in random_request(input logic [31:0] pool_base);
        t_in req;
        int  roll;
        req.frame_index    = ($urandom_range(0, 99) < 85) ?
                             pool_base + $urandom_range(0, 23) : $urandom();
        req.item_width     = DIM_W'($urandom_range(0, 16383));
        req.item_height    = DIM_W'($urandom_range(0, 16383));
        req.planes_present = 1'($urandom_range(0, 1));
        roll = $urandom_range(0, 99);
        if (roll < 4) begin
            req.mode = MODE_CLEAR;
        end else if (roll < 50) begin
            req.mode = MODE_STORE;
            case ($urandom_range(0, 19))
                0: begin
                    req.item_width     = want_w;
                    req.item_height    = want_h;
                    req.planes_present = 1'b0;
                end
                1: req.item_height = want_h;
                2: req.item_width  = want_w;
                default: begin
                    req.item_width     = want_w;
                    req.item_height    = want_h;
                    req.planes_present = 1'b1;
                end
            endcase
        end else if (roll < 76) begin
            req.mode = MODE_LOOKUP;
        end else begin
            req.mode = MODE_PROBE;
        end
        return req;
    endfunction

    // entered and left at a falling edge; valid stays high between back-to-back transfers
    task automatic push_request(input t_in req);
        int gap;
        gap = draw_gap();
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid <= 1'b1;
        in_req   <= req;
        do @(posedge clk); while (in_stall);
        @(negedge clk);
    endtask

    task automatic settle();
        in_valid <= 1'b0;
        do @(negedge clk); while (pending != 0);
    endtask

    task automatic set_frame_size(input logic [DIM_W-1:0] w, input logic [DIM_W-1:0] h);
        cfg_valid <= 1'b1;
        cfg_index <= CFG_EXP_WIDTH;
        cfg_data  <= w;
        do @(posedge clk); while (!cfg_ready);
        @(negedge clk);
        cfg_index <= CFG_EXP_HEIGHT;
        cfg_data  <= h;
        do @(posedge clk); while (!cfg_ready);
        @(negedge clk);
        cfg_valid <= 1'b0;
        want_w = w;
        want_h = h;
    endtask

    task automatic run_directed();
        push_request(mk(MODE_LOOKUP, 32'h0, 14'd0, 14'd0, 1'b0));
        push_request(mk(MODE_PROBE, 32'hFFFF_FFFF, 14'h3FFF, 14'h3FFF, 1'b1));
        push_request(mk(MODE_STORE, 32'h0, 14'd1920, 14'd1080, 1'b1));
        push_request(mk(MODE_STORE, 32'hFFFF_FFFF, 14'd1920, 14'd1080, 1'b1));
        // store of a cached frame is a hit and refreshes its age
        push_request(mk(MODE_STORE, 32'h0, 14'd1920, 14'd1080, 1'b1));
        push_request(mk(MODE_LOOKUP, 32'hFFFF_FFFF, 14'd0, 14'd0, 1'b0));
        push_request(mk(MODE_PROBE, 32'h0, 14'd0, 14'd0, 1'b0));
        // rejection wins even though the frame is cached
        push_request(mk(MODE_STORE, 32'h0, 14'd1920, 14'd1080, 1'b0));
        push_request(mk(MODE_STORE, 32'd5, 14'h3FFF, 14'd1080, 1'b1));
        push_request(mk(MODE_STORE, 32'd5, 14'd1920, 14'd0, 1'b1));
        for (int i = 0; i < SLOTS - 2; i++)
            push_request(mk(MODE_STORE, 32'd100 + i, 14'd1920, 14'd1080, 1'b1));
        push_request(mk(MODE_STORE, 32'd200, 14'd1920, 14'd1080, 1'b1));
        push_request(mk(MODE_CLEAR, 32'h5555_AAAA, 14'h2AAA, 14'h1555, 1'b1));
        push_request(mk(MODE_LOOKUP, 32'd100, 14'd0, 14'd0, 1'b0));
    endtask

    initial begin
        logic [31:0] pool_base;
        repeat (11) @(negedge clk);
        rst_n <= 1'b1;
        run_directed();
        for (int chunk = 0; chunk < CHUNKS; chunk++) begin
            if (chunk > 0) begin
                settle();
                case (chunk)
                    1: set_frame_size(14'd0, 14'd0);
                    2: set_frame_size(14'h3FFF, 14'h3FFF);
                    3: set_frame_size(14'd0, 14'h3FFF);
                    4: set_frame_size(14'h3FFF, 14'd0);
                    5: set_frame_size(DIM_W'($urandom_range(0, 16383)),
                                      DIM_W'($urandom_range(0, 16383)));
                    default: set_frame_size(14'd1920, 14'd1080);
                endcase
            end
            calm      = (chunk % 3 == 2);
            pool_base = $urandom();
            repeat (CHUNK) push_request(random_request(pool_base));
        end
        settle();
        repeat (SLOTS + 4) @(negedge clk);
        if (fail_count == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
